FILE: hdl/rsp_pkg.sv
package rsp_pkg;

  // Default sizing of the block
  localparam int MAX_DIM_DEF      = 32;
  localparam int MAX_CHANNELS_DEF = 1024;
  localparam int SUM_WIDTH_DEF    = 32;

  // Rectified value: -pixel - shrink needs one bit beyond p - a
  localparam int RECT_W = 18;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;

  // Fixed field widths
  localparam int CHAN_OUT_W = 10;
  localparam int RES_SUM_W  = 32;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Register indexes
  localparam logic [2:0] REG_WIDTH_PX      = 3'd0;
  localparam logic [2:0] REG_HEIGHT_PX     = 3'd1;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [2:0] REG_SPLIT_INDEX   = 3'd3;
  localparam logic [2:0] REG_SHRINK        = 3'd4;
  localparam logic [2:0] REG_FLOOR_VALUE   = 3'd5;

  // Reset values of the registers
  localparam logic [5:0]         WIDTH_PX_RST      = 6'd19;
  localparam logic [5:0]         HEIGHT_PX_RST     = 6'd19;
  localparam logic [10:0]        CHANNEL_COUNT_RST = 11'd1;
  localparam logic [4:0]         SPLIT_INDEX_RST   = 5'd9;
  localparam logic signed [15:0] SHRINK_RST        = 16'sd0;
  localparam logic signed [15:0] FLOOR_VALUE_RST   = 16'sd0;

  typedef struct packed {
    logic [5:0]         width_px;
    logic [5:0]         height_px;
    logic [10:0]        channel_count;
    logic [4:0]         split_index;
    logic signed [15:0] shrink;
    logic signed [15:0] floor_value;
  } rsp_cfg_t;

  // One classified pixel on its way to the accumulators
  typedef struct packed {
    logic signed [RECT_W-1:0] up;
    logic signed [RECT_W-1:0] down;
    logic [1:0]               xb;    // column pool membership, bit per pool
    logic [1:0]               yb;    // row pool membership, bit per pool
    logic                     eoc;   // last pixel of its channel
    logic                     done;  // channel is the last of the image
  } rsp_entry_t;

endpackage

FILE: hdl/rsp_stream_if.sv
interface rsp_pix_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface rsp_res_if;
  logic               valid;
  logic               ready;
  logic [9:0]         channel;
  logic               polarity;
  logic               pool_col;
  logic               pool_row;
  logic signed [31:0] sum;
  logic               last;
  logic               image_done;

  modport source (output valid, output channel, output polarity, output pool_col,
                  output pool_row, output sum, output last, output image_done,
                  input ready);
  modport sink   (input valid, input channel, input polarity, input pool_col,
                  input pool_row, input sum, input last, input image_done,
                  output ready);
endinterface

FILE: hdl/rsp_cfg.sv
module rsp_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rsp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rsp_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output rsp_pkg::rsp_cfg_t              cfg_o
);
  import rsp_pkg::*;

  rsp_cfg_t   cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_px      <= WIDTH_PX_RST;
      cfg_q.height_px     <= HEIGHT_PX_RST;
      cfg_q.channel_count <= CHANNEL_COUNT_RST;
      cfg_q.split_index   <= SPLIT_INDEX_RST;
      cfg_q.shrink        <= SHRINK_RST;
      cfg_q.floor_value   <= FLOOR_VALUE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_WIDTH_PX:      cfg_q.width_px      <= pwdata[5:0];
        REG_HEIGHT_PX:     cfg_q.height_px     <= pwdata[5:0];
        REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[10:0];
        REG_SPLIT_INDEX:   cfg_q.split_index   <= pwdata[4:0];
        REG_SHRINK:        cfg_q.shrink        <= pwdata[15:0];
        REG_FLOOR_VALUE:   cfg_q.floor_value   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH_PX:      prdata = {26'd0, cfg_q.width_px};
      REG_HEIGHT_PX:     prdata = {26'd0, cfg_q.height_px};
      REG_CHANNEL_COUNT: prdata = {21'd0, cfg_q.channel_count};
      REG_SPLIT_INDEX:   prdata = {27'd0, cfg_q.split_index};
      REG_SHRINK:        prdata = {16'd0, cfg_q.shrink};
      REG_FLOOR_VALUE:   prdata = {16'd0, cfg_q.floor_value};
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: hdl/rsp_front.sv
module rsp_front #(
  parameter int MAX_DIM      = rsp_pkg::MAX_DIM_DEF,
  parameter int MAX_CHANNELS = rsp_pkg::MAX_CHANNELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rsp_pkg::rsp_cfg_t  cfg_i,
  rsp_pix_if.sink            pix_i,
  output logic               push_o,
  input  logic               full_i,
  output rsp_pkg::rsp_entry_t entry_o
);
  import rsp_pkg::*;

  localparam int POS_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = ((DIM_W > 6) ? DIM_W : 6) + 1;
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCB_W  = $clog2(MAX_CHANNELS + 1);
  localparam int NC_W   = ((NCB_W > 11) ? NCB_W : 11) + 1;

  logic [POS_W-1:0] col_q, col_d, row_q, row_d;
  logic [CH_W-1:0]  chan_q, chan_d;
  logic [CMP_W-1:0] w_eff, h_eff, col_nx, row_nx, col_ext, row_ext, split_ext;
  logic [NC_W-1:0]  nc_eff, chan_nx;
  logic             col_wrap, row_wrap, done;
  logic signed [RECT_W-1:0] up_raw, down_raw, fl_ext;

  assign pix_i.ready = !full_i;
  assign push_o      = pix_i.valid && !full_i;

  // Dimensions and channel count: zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (cfg_i.width_px == '0)                      w_eff = CMP_W'(1);
    else if (CMP_W'(cfg_i.width_px) > CMP_W'(MAX_DIM)) w_eff = CMP_W'(MAX_DIM);
    else                                           w_eff = CMP_W'(cfg_i.width_px);
    if (cfg_i.height_px == '0)                      h_eff = CMP_W'(1);
    else if (CMP_W'(cfg_i.height_px) > CMP_W'(MAX_DIM)) h_eff = CMP_W'(MAX_DIM);
    else                                            h_eff = CMP_W'(cfg_i.height_px);
    if (cfg_i.channel_count == '0)                 nc_eff = NC_W'(1);
    else if (NC_W'(cfg_i.channel_count) > NC_W'(MAX_CHANNELS)) nc_eff = NC_W'(MAX_CHANNELS);
    else                                           nc_eff = NC_W'(cfg_i.channel_count);
  end

  assign col_ext   = CMP_W'(col_q);
  assign row_ext   = CMP_W'(row_q);
  assign split_ext = CMP_W'(cfg_i.split_index);
  assign col_nx    = col_ext + CMP_W'(1);
  assign row_nx    = row_ext + CMP_W'(1);
  assign col_wrap  = !(col_nx < w_eff);
  assign row_wrap  = !(row_nx < h_eff);
  assign chan_nx   = NC_W'(chan_q) + NC_W'(1);
  assign done      = chan_nx >= nc_eff;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    chan_d = chan_q;
    if (push_o) begin
      if (!col_wrap) begin
        col_d = col_nx[POS_W-1:0];
      end else begin
        col_d = '0;
        if (!row_wrap) begin
          row_d = row_nx[POS_W-1:0];
        end else begin
          row_d  = '0;
          chan_d = done ? '0 : chan_nx[CH_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      chan_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      chan_q <= chan_d;
    end
  end

  // Symmetric rectification, clamped below by the floor
  assign up_raw   = RECT_W'(pix_i.pixel) - RECT_W'(cfg_i.shrink);
  assign down_raw = -RECT_W'(pix_i.pixel) - RECT_W'(cfg_i.shrink);
  assign fl_ext   = RECT_W'(cfg_i.floor_value);

  always_comb begin
    entry_o.up   = (up_raw < fl_ext) ? fl_ext : up_raw;
    entry_o.down = (down_raw < fl_ext) ? fl_ext : down_raw;
    if (col_ext < split_ext)       entry_o.xb = 2'b01;
    else if (col_ext == split_ext) entry_o.xb = 2'b11;
    else                           entry_o.xb = 2'b10;
    if (row_ext < split_ext)       entry_o.yb = 2'b01;
    else if (row_ext == split_ext) entry_o.yb = 2'b11;
    else                           entry_o.yb = 2'b10;
    entry_o.eoc  = col_wrap && row_wrap;
    entry_o.done = done;
  end

endmodule

FILE: hdl/rsp_fifo.sv
module rsp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  rsp_pkg::rsp_entry_t wr_data_i,
  input  logic                pop_i,
  output logic                valid_o,
  output rsp_pkg::rsp_entry_t rd_data_o
);
  import rsp_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  rsp_entry_t       mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o    = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (PTR_W+1)'(1);
        2'b01:   cnt_q <= cnt_q - (PTR_W+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: hdl/rsp_back.sv
module rsp_back #(
  parameter int MAX_CHANNELS = rsp_pkg::MAX_CHANNELS_DEF,
  parameter int SUM_WIDTH    = rsp_pkg::SUM_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  rsp_pkg::rsp_entry_t entry_i,
  output logic                pop_o,
  rsp_res_if.source           res_o
);
  import rsp_pkg::*;

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic signed [SUM_WIDTH-1:0] sums_q  [8];
  logic signed [SUM_WIDTH-1:0] drain_q [8];
  logic signed [SUM_WIDTH-1:0] add_w   [8];
  logic [CH_W-1:0]             chan_q, out_chan_q;
  logic [CH_W+CHAN_OUT_W-1:0]  chan_wide;
  logic                        out_done_q, drain_act_q;
  logic [2:0]                  idx_q;
  logic                        take, load_ok, load;

  assign take    = res_o.valid && res_o.ready;
  assign load_ok = !drain_act_q || (take && idx_q == 3'd7);
  assign pop_o   = valid_i && (!entry_i.eoc || load_ok);
  assign load    = pop_o && entry_i.eoc;

  // Contribution of the popped pixel to each pool sum
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if (entry_i.yb[(k >> 1) & 1] && entry_i.xb[k & 1]) begin
        add_w[k] = (k >= 4) ? SUM_WIDTH'(entry_i.down) : SUM_WIDTH'(entry_i.up);
      end else begin
        add_w[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 8; k++) sums_q[k] <= '0;
    end else if (pop_o) begin
      for (int k = 0; k < 8; k++) sums_q[k] <= entry_i.eoc ? '0 : sums_q[k] + add_w[k];
    end
  end

  // Snapshot a finished channel into the drain buffer
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int k = 0; k < 8; k++) drain_q[k] <= sums_q[k] + add_w[k];
      out_chan_q <= chan_q;
      out_done_q <= entry_i.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q      <= '0;
      drain_act_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        chan_q      <= entry_i.done ? '0 : chan_q + CH_W'(1);
        drain_act_q <= 1'b1;
        idx_q       <= '0;
      end else if (take) begin
        if (idx_q == 3'd7) drain_act_q <= 1'b0;
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  assign chan_wide        = {{CHAN_OUT_W{1'b0}}, out_chan_q};
  assign res_o.valid      = drain_act_q;
  assign res_o.channel    = chan_wide[CHAN_OUT_W-1:0];
  assign res_o.polarity   = idx_q[2];
  assign res_o.pool_row   = idx_q[1];
  assign res_o.pool_col   = idx_q[0];
  assign res_o.sum        = RES_SUM_W'(drain_q[idx_q]);
  assign res_o.last       = (idx_q == 3'd7);
  assign res_o.image_done = out_done_q;

endmodule

FILE: hdl/rectify_and_sum_pool_core.sv
// Symmetric rectification and 2x2 sum pooling. Pixels (signed Q4.12) enter in
// raster order, column fastest, one channel after another; each pixel yields
// max(floor_value, p - shrink) and max(floor_value, -p - shrink), which are
// added into the positive and negative sums of every pool its column and row
// belong to (below split_index pool 0, equal to it both pools, above it pool
// 1). After a channel's last pixel eight sums come out, polarity 0 first and
// row-major within each polarity, with last on the eighth and image_done on
// every result of the image's final channel. Sustained rate is one pixel per
// cycle while results are taken: the front classifies and counts positions
// at one pixel a cycle, a four-entry queue feeds the accumulators, and a
// finished channel moves to a drain buffer that emits one result per cycle
// while the next channel accumulates. A channel of fewer than eight pixels
// holds the queue until the drain buffer frees, so such images run at its
// pace. Results are offered once the last pixel has passed the queue into the
// drain buffer. Sums wrap modulo 2^SUM_WIDTH. The user must write registers
// over the APB port only while no item is in flight, which is not enforced.
module rectify_and_sum_pool_core #(
  parameter int MAX_DIM      = rsp_pkg::MAX_DIM_DEF,
  parameter int MAX_CHANNELS = rsp_pkg::MAX_CHANNELS_DEF,
  parameter int SUM_WIDTH    = rsp_pkg::SUM_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rsp_pix_if.sink                        pix_i,
  rsp_res_if.source                      res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rsp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rsp_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rsp_pkg::*;

  rsp_cfg_t   cfg;
  rsp_entry_t wr_entry, rd_entry;
  logic       push, full, pop, q_valid;

  // Register file
  rsp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Front: take pixels, rectify, track position and channel end
  rsp_front #(
    .MAX_DIM      (MAX_DIM),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .pix_i   (pix_i),
    .push_o  (push),
    .full_i  (full),
    .entry_o (wr_entry)
  );

  // Decouple the front from the accumulators
  rsp_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .wr_data_i (wr_entry),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .rd_data_o (rd_entry)
  );

  // Back: accumulate pool sums and drain them per channel
  rsp_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (rd_entry),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

FILE: hdl/rsp_checker.sv
module rsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [9:0]  res_channel_i,
  input logic        res_polarity_i,
  input logic        res_pool_col_i,
  input logic        res_pool_row_i,
  input logic [31:0] res_sum_i,
  input logic        res_last_i
);

  // Stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_sum_i) &&
      $stable(res_channel_i) && $stable(res_last_i))
    else $error("result changed while stalled");

  // Last result of a channel is the negative row 1 col 1 sum
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_last_i |-> res_polarity_i && res_pool_col_i && res_pool_row_i)
    else $error("last flag on wrong pool");

  // A channel's results come without gaps
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !res_last_i |=> res_valid_i)
    else $error("gap inside a channel's results");

  // All eight results of a channel carry the same channel index
  a_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !res_last_i |=> res_channel_i == $past(res_channel_i))
    else $error("channel index changed inside a channel");

endmodule

bind rectify_and_sum_pool_core rsp_checker u_rsp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_channel_i  (res_o.channel),
  .res_polarity_i (res_o.polarity),
  .res_pool_col_i (res_o.pool_col),
  .res_pool_row_i (res_o.pool_row),
  .res_sum_i      (res_o.sum),
  .res_last_i     (res_o.last)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rsp_pkg::*;

  localparam int SETTLE_CYCLES  = 24;    // queue, drain buffer and output slack
  localparam int TAIL_CYCLES    = 24;
  localparam int STALL_LIMIT    = 4000;  // cycles in a row with nothing accepted
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_ITEMS    = 38;
  localparam int PRESSURE_POINT = 20;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

  // One directed step: a register write or a pixel, the latter optionally
  // carrying the sums it must produce when it ends a 1x1 channel.
  typedef struct packed {
    row_kind_e          kind;
    logic [2:0]         regno;
    logic [31:0]        value;
    logic               typed;
    logic signed [31:0] up_sum;
    logic signed [31:0] dn_sum;
  } stim_row_t;

  typedef struct packed {
    logic [9:0]         channel;
    logic               polarity;
    logic               pool_col;
    logic               pool_row;
    logic signed [31:0] sum;
    logic               last;
    logic               image_done;
  } pool_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic        pready;

  rsp_pix_if pix ();
  rsp_res_if res ();

  rectify_and_sum_pool_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Shadow of the block: settings, raster position and the eight pool sums
  rsp_cfg_t    cfg_shadow;
  int          col_pos;
  int          row_pos;
  int          chan_pos;
  logic [31:0] pool_acc [8];

  pool_res_t   pool_exp_q [$];
  pool_res_t   want_res;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  pix_held;
  int  idle_cycles;
  int  mismatches;
  int  sums_checked;
  int  pixels_sent;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic int dim_of(input logic [10:0] v, input int max_v);
    if (v == 0) return 1;
    if (v > max_v) return max_v;
    return int'(v);
  endfunction

  // Bit 0: coordinate lies in pool 0, bit 1: in pool 1.
  function automatic logic [1:0] pool_membership(input int pos, input int split);
    if (pos < split) return 2'b01;
    if (pos == split) return 2'b11;
    return 2'b10;
  endfunction

  function automatic void store_setting(input logic [2:0] regno, input logic [31:0] data);
    case (regno)
      REG_WIDTH_PX:      cfg_shadow.width_px      = data[5:0];
      REG_HEIGHT_PX:     cfg_shadow.height_px     = data[5:0];
      REG_CHANNEL_COUNT: cfg_shadow.channel_count = data[10:0];
      REG_SPLIT_INDEX:   cfg_shadow.split_index   = data[4:0];
      REG_SHRINK:        cfg_shadow.shrink        = data[15:0];
      REG_FLOOR_VALUE:   cfg_shadow.floor_value   = data[15:0];
      default: ;
    endcase
  endfunction

  // Rectify one pixel, add it into its pools and advance the raster position.
  // Returns the number of pool sums the pixel releases (0 or 8).
  function automatic int predict_pixel(input logic signed [15:0] px,
                                       output pool_res_t sums [8]);
    logic signed [31:0] up;
    logic signed [31:0] dn;
    logic signed [31:0] alpha;
    logic signed [31:0] fl;
    logic [1:0]         xb;
    logic [1:0]         yb;
    int                 w;
    int                 h;
    int                 nc;
    bit                 done;
    alpha = 32'(cfg_shadow.shrink);
    fl    = 32'(cfg_shadow.floor_value);
    up    = 32'(px) - alpha;
    dn    = -32'(px) - alpha;
    if (up < fl) up = fl;
    if (dn < fl) dn = fl;
    w  = dim_of(11'(cfg_shadow.width_px), MAX_DIM_DEF);
    h  = dim_of(11'(cfg_shadow.height_px), MAX_DIM_DEF);
    nc = dim_of(cfg_shadow.channel_count, MAX_CHANNELS_DEF);
    xb = pool_membership(col_pos, int'(cfg_shadow.split_index));
    yb = pool_membership(row_pos, int'(cfg_shadow.split_index));
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 2; c++) begin
        if (yb[r] && xb[c]) begin
          pool_acc[r*2 + c]     += up;
          pool_acc[4 + r*2 + c] += dn;
        end
      end
    end
    // A position at or past a shrunk size wraps as if it were the last one
    if (col_pos + 1 < w) begin
      col_pos++;
      return 0;
    end
    col_pos = 0;
    if (row_pos + 1 < h) begin
      row_pos++;
      return 0;
    end
    row_pos = 0;
    done = (chan_pos + 1 >= nc);
    for (int k = 0; k < 8; k++) begin
      sums[k].channel    = chan_pos[9:0];
      sums[k].polarity   = k[2];
      sums[k].pool_row   = k[1];
      sums[k].pool_col   = k[0];
      sums[k].sum        = pool_acc[k];
      sums[k].last       = (k == 7);
      sums[k].image_done = done;
      pool_acc[k]        = '0;
    end
    chan_pos = done ? 0 : chan_pos + 1;
    return 8;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d (channel %0d, slot p%0d r%0d c%0d)",
                                name, got, want, want_res.channel, want_res.polarity,
                                want_res.pool_row, want_res.pool_col));
  endtask

  // Sample both channels at the clock edge; the values read here are the ones
  // the block saw, since every stimulus change is a nonblocking update.
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (res.valid && res.ready) begin
      if (pool_exp_q.size() == 0) begin
        report_mismatch($sformatf("pool sum %0d of channel %0d with nothing expected",
                                  res.sum, res.channel));
      end else begin
        want_res = pool_exp_q.pop_front();
        check_field("channel", 32'(res.channel), 32'(want_res.channel));
        check_field("polarity", 32'(res.polarity), 32'(want_res.polarity));
        check_field("pool_col", 32'(res.pool_col), 32'(want_res.pool_col));
        check_field("pool_row", 32'(res.pool_row), 32'(want_res.pool_row));
        check_field("sum", res.sum, want_res.sum);
        check_field("last", 32'(res.last), 32'(want_res.last));
        check_field("image_done", 32'(res.image_done), 32'(want_res.image_done));
        sums_checked++;
      end
    end
  end

  // Receiver: drop ready at random according to the current stall rate
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when nothing has moved for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Timeout: no item accepted for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
      default: begin send_idle_pct = 7; recv_stall_pct = 7; end
    endcase
  endtask

  // APB write: setup, access, then release of the bus
  task automatic apb_write(input logic [2:0] regno, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regno, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    store_setting(regno, data);
  endtask

  // Lower valid once after the last accepted item; callers always wait after
  task automatic pix_idle();
    if (pix_held) begin
      pix.valid <= 1'b0;
      pix_held = 1'b0;
    end
  endtask

  // Hold a pixel until the block takes it, then queue what it releases.
  // A typed pixel overrides the predicted sums with the hand-derived ones.
  task automatic send_pixel(input logic signed [15:0] px, input logic typed,
                            input logic signed [31:0] up_sum,
                            input logic signed [31:0] dn_sum);
    pool_res_t sums [8];
    int        gap;
    int        n;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      pix_idle();
      repeat (gap) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.pixel <= px;
    pix_held = 1'b1;
    do @(posedge clk_i); while (!pix.ready);
    n = predict_pixel(px, sums);
    for (int k = 0; k < n; k++) begin
      if (typed) sums[k].sum = sums[k].polarity ? dn_sum : up_sum;
      pool_exp_q.push_back(sums[k]);
    end
    pixels_sent++;
  endtask

  // Wait until every queued sum has come out
  task automatic wait_drained();
    pix_idle();
    do @(posedge clk_i); while (pool_exp_q.size() != 0);
  endtask

  // Let in-flight pixels that release nothing clear the block before a write
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic stim_row_t cfg_row(input logic [2:0] regno, input logic [31:0] v);
    return '{ROW_CFG, regno, v, 1'b0, 32'sd0, 32'sd0};
  endfunction

  function automatic stim_row_t pix_row(input logic signed [15:0] px);
    return '{ROW_PIX, REG_WIDTH_PX, 32'(px), 1'b0, 32'sd0, 32'sd0};
  endfunction

  function automatic stim_row_t sum_row(input logic signed [15:0] px,
                                        input logic signed [31:0] up_sum,
                                        input logic signed [31:0] dn_sum);
    return '{ROW_PIX, REG_WIDTH_PX, 32'(px), 1'b1, up_sum, dn_sum};
  endfunction

  // Mostly uniform pixels, with the rails, zero and minus one now and then
  function automatic logic signed [15:0] rand_pixel();
    if ($urandom_range(7) != 0) return 16'($urandom);
    case ($urandom_range(3))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  initial begin : main
    stim_row_t   dir_tab [$];
    bit          pix_since_write;
    logic [31:0] w, h, c, s, a, f;
    pix.valid     <= 1'b0;
    pix.pixel     <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_ni        <= 1'b0;
    pix_held       = 1'b0;
    mismatches     = 0;
    sums_checked   = 0;
    pixels_sent    = 0;
    cfg_shadow     = '{WIDTH_PX_RST, HEIGHT_PX_RST, CHANNEL_COUNT_RST, SPLIT_INDEX_RST,
                       SHRINK_RST, FLOOR_VALUE_RST};
    col_pos        = 0;
    row_pos        = 0;
    chan_pos       = 0;
    foreach (pool_acc[k]) pool_acc[k] = '0;
    set_idling(0);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. With a 1x1 image and split 0 every pixel lies in all four
    // pools, so each channel repeats max(floor, p - a) and max(floor, -p - a).
    dir_tab = '{
      cfg_row(REG_WIDTH_PX, 32'd1),
      cfg_row(REG_HEIGHT_PX, 32'd1),
      pix_row(16'sd5),                                   // reset split: pool 0 only
      cfg_row(REG_SPLIT_INDEX, 32'd0),
      sum_row(16'sh7fff, 32'sd32767, 32'sd0),
      sum_row(16'sh8000, 32'sd0, 32'sd32768),
      sum_row(16'sh0000, 32'sd0, 32'sd0),
      cfg_row(REG_SHRINK, 32'h0000_8000),
      sum_row(16'sh7fff, 32'sd65535, 32'sd1),
      sum_row(16'sh8000, 32'sd0, 32'sd65536),
      cfg_row(REG_SHRINK, 32'h0000_7fff),
      cfg_row(REG_FLOOR_VALUE, 32'h0000_8000),
      sum_row(16'sh0000, -32'sd32767, -32'sd32767),
      sum_row(16'sh8000, -32'sd32768, 32'sd1),
      cfg_row(REG_FLOOR_VALUE, 32'h0000_7fff),
      sum_row(16'sd1, 32'sd32767, 32'sd32767),           // floor wins on both halves
      cfg_row(REG_SHRINK, 32'd0),
      cfg_row(REG_FLOOR_VALUE, 32'd0),
      cfg_row(REG_WIDTH_PX, 32'd0),                      // zero sizes act as one
      cfg_row(REG_HEIGHT_PX, 32'd0),
      cfg_row(REG_CHANNEL_COUNT, 32'd0),
      sum_row(16'sd100, 32'sd100, 32'sd0),
      cfg_row(REG_WIDTH_PX, 32'd2),
      cfg_row(REG_HEIGHT_PX, 32'd2),
      cfg_row(REG_CHANNEL_COUNT, 32'd2),
      cfg_row(REG_SPLIT_INDEX, 32'd5),                   // split past the size
      pix_row(16'sd1234), pix_row(-16'sd4321), pix_row(16'sd16384), pix_row(-16'sd1),
      cfg_row(REG_SPLIT_INDEX, 32'd1),
      pix_row(16'sh7fff), pix_row(16'sh8000), pix_row(16'sd77), pix_row(-16'sd900)
    };
    pix_since_write = 1'b0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        if (pix_since_write) settle();
        pix_since_write = 1'b0;
        apb_write(dir_tab[i].regno, dir_tab[i].value);
      end else begin
        send_pixel(dir_tab[i].value[15:0], dir_tab[i].typed,
                   dir_tab[i].up_sum, dir_tab[i].dn_sum);
        pix_since_write = 1'b1;
      end
    end

    // Random phases: new settings each time, the idling pattern rotating.
    // Phases may end mid-channel, so shrinking sizes can also exercise the wrap of a
    // position that lies past the new size.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      c = $urandom_range(1, 4);
      s = $urandom_range(0, 7);
      a = 32'(16'($urandom));
      f = 32'(16'($urandom));
      case (ph)
        4: begin w = 63; h = 1;  c = 2047; s = 31; a = 32'h8000; f = 32'h8000; end
        5: begin w = 1;  h = 63; c = 1;    s = 0;  a = 32'h7fff; f = 32'h7fff; end
        6: begin w = 0;  h = 0;  c = 0;    s = 0;  end
        7: begin w = 63; h = 63; c = 2;    s = $urandom_range(0, 31); end
        default: ;
      endcase
      apb_write(REG_WIDTH_PX, w);
      apb_write(REG_HEIGHT_PX, h);
      apb_write(REG_CHANNEL_COUNT, c);
      apb_write(REG_SPLIT_INDEX, s);
      apb_write(REG_SHRINK, a);
      apb_write(REG_FLOOR_VALUE, f);
      set_idling(ph % 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Hold the stream until every queued sum has come out, once per phase
        if (i == PRESSURE_POINT) wait_drained();
        send_pixel(rand_pixel(), 1'b0, 32'sd0, 32'sd0);
      end
    end

    // Drain, then give late or extra results time to show up
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pool_exp_q.size() != 0)
      report_mismatch($sformatf("%0d pool sums never arrived", pool_exp_q.size()));

    $display("Sent %0d pixels under %0d random setting phases plus a directed table",
             pixels_sent, RAND_PHASES);
    $display("Checked %0d pool sums, %0d mismatches", sums_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/rsp_pkg.sv
hdl/rsp_stream_if.sv
hdl/rsp_cfg.sv
hdl/rsp_front.sv
hdl/rsp_fifo.sv
hdl/rsp_back.sv
hdl/rectify_and_sum_pool_core.sv
hdl/rsp_checker.sv
tb/testbench.sv
